// ===== rtl/core/pbse_pkg.sv =====
package pbse_pkg;

	localparam int MAX_BITS_DEF  = 256;
	localparam int WORD_BITS_DEF = 64;

	// Field widths of the ports
	localparam int CFG_W   = 9;
	localparam int IDX_W   = 8;
	localparam int START_W = 10;

	// Internal bit positions: the size never exceeds 511, so 9 bits cover every position
	localparam int POS_W = 9;

	localparam int BITS_RST = 256;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_FIRST = 2'd2,
		KIND_NEXT  = 2'd3
	} kind_t;

	// Window for one word scan: positions in [lo, hi], optionally minus ex
	typedef struct packed {
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic [POS_W-1:0] ex;
		logic             ex_en;
		logic             up;
	} scan_ctl_t;

endpackage

// ===== rtl/core/pbse_scan.sv =====
module pbse_scan
	import pbse_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic [WORD_BITS-1:0]         word,
	input  logic [POS_W-1:0]             base,
	input  scan_ctl_t                    ctl,
	output logic                         hit,
	output logic [$clog2(WORD_BITS)-1:0] off,
	output logic [POS_W-1:0]             pos
);

	localparam int OW = $clog2(WORD_BITS);
	localparam int WP = 1 << OW;

	logic [WORD_BITS-1:0] cand;
	logic [WP-1:0]        pad;
	logic [WP-1:0]        rev;
	logic [POS_W:0]       p;
	logic [OW-1:0]        enc;

	// Binary search for the lowest set bit, one halving per level
	function automatic logic [OW-1:0] lowest(input logic [WP-1:0] v);
		logic [WP-1:0] t;
		logic [OW-1:0] n;
		t = v;
		n = '0;
		for (int l = OW - 1; l >= 0; l--) begin
			if ((t & ((WP'(1) << (1 << l)) - WP'(1))) == '0) begin
				t = t >> (1 << l);
				n = n + OW'(1 << l);
			end
		end
		return n;
	endfunction

	always_comb begin
		p = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			p = {1'b0, base} + (POS_W+1)'(k);
			cand[k] = word[k] && (p >= {1'b0, ctl.lo}) && (p <= {1'b0, ctl.hi})
				&& !(ctl.ex_en && (p == {1'b0, ctl.ex}));
		end
	end

	always_comb begin
		pad = WP'(cand);
		for (int k = 0; k < WP; k++) begin
			rev[k] = pad[WP-1-k];
		end
	end

	// Upward walks take the lowest candidate, downward walks the highest
	assign enc = ctl.up ? lowest(pad) : (OW'(WP - 1) - lowest(rev));
	assign hit = |cand;
	assign off = enc;
	assign pos = base + POS_W'(enc);

endmodule

// ===== rtl/core/packed_bitmap_search_engine.sv =====
// Packed bitmap with set/clear, read, find-first-set and find-next-with-wrap. The bit store
// is cleared by reset, with no sweep afterward, and an item is taken only when the engine is idle.
// Write and read pass through prepare, two word/offset split states, access and finish on the
// way to the result register. Find-first goes through prepare, the scan and finish; find-next
// also passes through the split before the scan. The scan visits W store words, one per cycle,
// through a single masked priority encoder. A downward find-next that wraps goes through the
// split a second time. With the default sizing, W is at most 4 for find-first and at most 5 for
// find-next. A result waits in its output register while the next transaction is accepted.
module packed_bitmap_search_engine
	import pbse_pkg::*;
#(
	parameter int MAX_BITS  = MAX_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [CFG_W-1:0]   bits_in_use,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [IDX_W-1:0]   bit_addr,
	input  logic               set_value,
	input  logic               range_check,
	input  logic               consume,
	input  logic [START_W-1:0] start_position,
	input  logic               search_up,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [IDX_W-1:0]   position,
	output logic               bit_value
);

	localparam int NW     = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
	localparam int OW     = $clog2(WORD_BITS);
	localparam int DIV_SH = POS_W + OW;
	localparam int DIV_M  = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int MW     = $clog2(DIV_M + 1);
	localparam int PRW    = POS_W + MW;

	localparam logic [CFG_W-1:0] SIZE_CAP = (MAX_BITS > 511) ? '1 : CFG_W'(MAX_BITS);
	localparam logic [CFG_W-1:0] SIZE_RST = (BITS_RST > MAX_BITS) ? SIZE_CAP : CFG_W'(BITS_RST);
	localparam logic [POS_W:0]   LIM_CAP  =
		(MAX_BITS > (1 << POS_W)) ? (POS_W+1)'(1 << POS_W) : (POS_W+1)'(MAX_BITS);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PREP   = 7'b0000010,
		ST_DIV1   = 7'b0000100,
		ST_DIV2   = 7'b0001000,
		ST_ACCESS = 7'b0010000,
		ST_SCAN   = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     size_q;
	logic [WORD_BITS-1:0] store_q [NW];

	kind_t                kind_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 set_q;
	logic                 chk_q;
	logic                 cons_q;
	logic [START_W-1:0]   start_q;
	logic                 up_q;

	logic [POS_W-1:0]     div_op_q;
	logic [PRW-1:0]       prod_s1;
	logic [AW-1:0]        wadr_q;
	logic [POS_W-1:0]     base_q;
	logic [OW-1:0]        off_q;
	scan_ctl_t            ctl_q;
	logic [POS_W-1:0]     p0_q;
	logic                 last_q;

	logic                 res_found_q;
	logic [POS_W-1:0]     res_pos_q;
	logic                 res_val_q;

	logic                 out_valid_q;
	logic                 found_q;
	logic [IDX_W-1:0]     position_q;
	logic                 bit_value_q;

	logic [POS_W-1:0]     size_m1;
	logic [START_W:0]     nx_t;
	logic [POS_W-1:0]     nx_p0;
	logic [POS_W-1:0]     nx_ex;
	logic [POS_W:0]       ff_lim;
	logic [POS_W:0]       ff_lim_c;
	logic [POS_W-1:0]     ff_hi;
	logic [POS_W-1:0]     div_q;
	logic [POS_W-1:0]     div_qw;
	logic [POS_W-1:0]     div_rem;
	logic                 idx_ok;
	logic                 wr_ok;
	logic                 sc_hit;
	logic [OW-1:0]        sc_off;
	logic [POS_W-1:0]     sc_pos;
	logic                 sc_end;
	logic                 st_we;
	logic [OW-1:0]        st_bit;
	logic                 st_val;
	logic                 out_load;

	pbse_scan #(
		.WORD_BITS(WORD_BITS)
	) u_scan (
		.word (store_q[wadr_q]),
		.base (base_q),
		.ctl  (ctl_q),
		.hit  (sc_hit),
		.off  (sc_off),
		.pos  (sc_pos)
	);

	assign size_m1 = size_q - CFG_W'(1);

	// First position of a find-next walk, after the wrap rule is applied once
	always_comb begin
		nx_t = {start_q[START_W-1], start_q} + (up_q ? (START_W+1)'(1) : '1);
		if (nx_t[START_W]) begin
			nx_p0 = size_m1;
		end else if (nx_t >= (START_W+1)'(size_q)) begin
			nx_p0 = '0;
		end else begin
			nx_p0 = nx_t[POS_W-1:0];
		end
		if (up_q) begin
			nx_ex = (nx_p0 == '0) ? size_m1 : (nx_p0 - POS_W'(1));
		end else begin
			nx_ex = (nx_p0 == size_m1) ? '0 : (nx_p0 + POS_W'(1));
		end
	end

	// Find-first covers whole bytes up to the size, capped at the store
	always_comb begin
		ff_lim   = ({1'b0, size_q} + (POS_W+1)'(7)) & ~(POS_W+1)'(7);
		ff_lim_c = (int'(ff_lim) > MAX_BITS) ? LIM_CAP : ff_lim;
		ff_hi    = POS_W'(ff_lim_c - (POS_W+1)'(1));
	end

	// Word and offset of div_op_q by reciprocal multiplication
	assign div_q   = POS_W'(prod_s1 >> DIV_SH);
	assign div_qw  = div_q * POS_W'(WORD_BITS);
	assign div_rem = div_op_q - div_qw;

	assign idx_ok = int'(idx_q) < MAX_BITS;
	assign wr_ok  = idx_ok && (!chk_q || ({1'b0, idx_q} < size_q));

	assign sc_end = ctl_q.up ?
		(({1'b0, base_q} + (POS_W+1)'(WORD_BITS)) > {1'b0, ctl_q.hi}) :
		(base_q <= ctl_q.lo);

	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	always_comb begin
		st_we  = 1'b0;
		st_bit = sc_off;
		st_val = 1'b0;
		if (state_q == ST_ACCESS && kind_q == KIND_WRITE && wr_ok) begin
			st_we  = 1'b1;
			st_bit = off_q;
			st_val = set_q;
		end else if (state_q == ST_SCAN && kind_q == KIND_FIRST && sc_hit && cons_q) begin
			st_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) begin
				store_q[i] <= '0;
			end
		end else if (st_we) begin
			store_q[wadr_q][st_bit] <= st_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= SIZE_RST;
			kind_q      <= KIND_WRITE;
			idx_q       <= '0;
			set_q       <= 1'b0;
			chk_q       <= 1'b0;
			cons_q      <= 1'b0;
			start_q     <= '0;
			up_q        <= 1'b0;
			div_op_q    <= '0;
			prod_s1     <= '0;
			wadr_q      <= '0;
			base_q      <= '0;
			off_q       <= '0;
			ctl_q       <= '0;
			p0_q        <= '0;
			last_q      <= 1'b0;
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
			res_val_q   <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			position_q  <= '0;
			bit_value_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				size_q <= (int'(bits_in_use) > MAX_BITS) ? SIZE_CAP : bits_in_use;
			end
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: if (in_valid) begin
					kind_q  <= kind_t'(kind);
					idx_q   <= bit_addr;
					set_q   <= set_value;
					chk_q   <= range_check;
					cons_q  <= consume;
					start_q <= start_position;
					up_q    <= search_up;
					state_q <= ST_PREP;
				end

				ST_PREP: begin
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
					res_val_q   <= 1'b0;
					case (kind_q)
						KIND_WRITE, KIND_READ: begin
							div_op_q <= POS_W'(idx_q);
							state_q  <= ST_DIV1;
						end
						KIND_FIRST: begin
							if (ff_lim_c == '0) begin
								state_q <= ST_FINISH;
							end else begin
								ctl_q.lo    <= '0;
								ctl_q.hi    <= ff_hi;
								ctl_q.ex    <= '0;
								ctl_q.ex_en <= 1'b0;
								ctl_q.up    <= 1'b1;
								wadr_q      <= '0;
								base_q      <= '0;
								last_q      <= 1'b1;
								state_q     <= ST_SCAN;
							end
						end
						default: begin
							if (size_q <= CFG_W'(1)) begin
								state_q <= ST_FINISH;
							end else begin
								// First pass runs from p0 toward the end of the walk's direction
								p0_q        <= nx_p0;
								ctl_q.lo    <= up_q ? nx_p0 : '0;
								ctl_q.hi    <= up_q ? size_m1 : nx_p0;
								ctl_q.ex    <= nx_ex;
								ctl_q.ex_en <= 1'b1;
								ctl_q.up    <= up_q;
								div_op_q    <= nx_p0;
								last_q      <= 1'b0;
								state_q     <= ST_DIV1;
							end
						end
					endcase
				end

				ST_DIV1: begin
					prod_s1 <= PRW'(div_op_q) * PRW'(DIV_M);
					state_q <= ST_DIV2;
				end

				ST_DIV2: begin
					wadr_q  <= AW'(div_q);
					base_q  <= div_qw;
					off_q   <= div_rem[OW-1:0];
					state_q <= (kind_q == KIND_WRITE || kind_q == KIND_READ) ? ST_ACCESS : ST_SCAN;
				end

				ST_ACCESS: begin
					if (kind_q == KIND_READ) begin
						res_val_q <= idx_ok && store_q[wadr_q][off_q];
					end
					state_q <= ST_FINISH;
				end

				ST_SCAN: begin
					if (sc_hit) begin
						if (kind_q == KIND_FIRST) begin
							// A hit past the size is not reported; it is cleared only when consume is set
							res_found_q <= sc_pos < size_q;
							res_pos_q   <= (sc_pos < size_q) ? sc_pos : '0;
						end else begin
							res_found_q <= 1'b1;
							res_pos_q   <= sc_pos;
						end
						state_q <= ST_FINISH;
					end else if (sc_end) begin
						if (last_q) begin
							state_q <= ST_FINISH;
						end else if (ctl_q.up) begin
							// Wrap to the bottom and walk up to just below p0
							if (p0_q != '0) begin
								ctl_q.lo <= '0;
								ctl_q.hi <= p0_q - POS_W'(1);
								wadr_q   <= '0;
								base_q   <= '0;
								last_q   <= 1'b1;
							end else begin
								state_q <= ST_FINISH;
							end
						end else begin
							// Wrap to the top and walk down to just above p0
							if (p0_q != size_m1) begin
								ctl_q.lo <= p0_q + POS_W'(1);
								ctl_q.hi <= size_m1;
								div_op_q <= size_m1;
								last_q   <= 1'b1;
								state_q  <= ST_DIV1;
							end else begin
								state_q <= ST_FINISH;
							end
						end
					end else if (ctl_q.up) begin
						wadr_q <= wadr_q + AW'(1);
						base_q <= base_q + POS_W'(WORD_BITS);
					end else begin
						wadr_q <= wadr_q - AW'(1);
						base_q <= base_q - POS_W'(WORD_BITS);
					end
				end

				ST_FINISH: if (out_load) begin
					out_valid_q <= 1'b1;
					found_q     <= res_found_q;
					position_q  <= res_pos_q[IDX_W-1:0];
					bit_value_q <= res_val_q;
					state_q     <= ST_IDLE;
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;
	assign bit_value = bit_value_q;

endmodule

// ===== tb/packed_bitmap_search_engine_test.sv =====
`timescale 1ns / 100ps

module packed_bitmap_search_engine_test;
	import pbse_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   bit_addr;
		logic               set_value;
		logic               range_check;
		logic               consume;
		logic [START_W-1:0] start_position;
		logic               search_up;
	} bitmap_op_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] position;
		logic             bit_value;
	} bitmap_answer_t;

	localparam int ARRAY_BITS      = MAX_BITS_DEF;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_REPORTS     = 10;

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               cfg_write      = 1'b0;
	logic [CFG_W-1:0]   bits_in_use    = CFG_W'(BITS_RST);
	logic               in_valid       = 1'b0;
	logic               in_stall;
	kind_t              kind           = KIND_WRITE;
	logic [IDX_W-1:0]   bit_addr       = '0;
	logic               set_value      = 1'b0;
	logic               range_check    = 1'b0;
	logic               consume        = 1'b0;
	logic [START_W-1:0] start_position = '0;
	logic               search_up      = 1'b0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic               found;
	logic [IDX_W-1:0]   position;
	logic               bit_value;

	// Shadow of the bit array and of the size register
	logic [ARRAY_BITS-1:0] bitmap_image = '0;
	int unsigned           size_setting = BITS_RST;

	bitmap_op_t     pending_ops[$];
	bitmap_answer_t expected_answers[$];
	bitmap_op_t     offered;

	int   send_gap_pct = 20;
	int   stall_pct    = 54;
	int   error_count  = 0;
	logic hold_trigger = 1'b0;
	logic hold_used    = 1'b0;
	int   hold_left    = 0;

	packed_bitmap_search_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.bits_in_use   (bits_in_use),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.bit_addr      (bit_addr),
		.set_value     (set_value),
		.range_check   (range_check),
		.consume       (consume),
		.start_position(start_position),
		.search_up     (search_up),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.position      (position),
		.bit_value     (bit_value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned active_size();
		return (size_setting > ARRAY_BITS) ? ARRAY_BITS : size_setting;
	endfunction

	// Apply one operation to the shadow array and return the answer it gives
	function automatic bitmap_answer_t predict_bitmap_op(bitmap_op_t op);
		int unsigned    size;
		int unsigned    limit;
		int             cur;
		logic           done;
		bitmap_answer_t ans;
		size = active_size();
		ans  = '0;
		done = 1'b0;
		case (op.kind)
			KIND_WRITE: begin
				if (!op.range_check || op.bit_addr < size)
					bitmap_image[op.bit_addr] = op.set_value;
			end
			KIND_READ: begin
				ans.bit_value = bitmap_image[op.bit_addr];
			end
			KIND_FIRST: begin
				// scan whole bytes; a hit past the size is not reported, and is cleared only on consume
				limit = (size + 7) & ~32'd7;
				if (limit > ARRAY_BITS)
					limit = ARRAY_BITS;
				for (int i = 0; i < limit; i++) begin
					if (!done && bitmap_image[i]) begin
						done = 1'b1;
						if (op.consume)
							bitmap_image[i] = 1'b0;
						if (i < size) begin
							ans.found    = 1'b1;
							ans.position = IDX_W'(i);
						end
					end
				end
			end
			KIND_NEXT: begin
				cur = $signed(op.start_position);
				for (int k = 1; k < size; k++) begin
					if (!done) begin
						cur += op.search_up ? 1 : -1;
						if (cur < 0)
							cur = int'(size) - 1;
						else if (cur >= int'(size))
							cur = 0;
						if (bitmap_image[cur]) begin
							done         = 1'b1;
							ans.found    = 1'b1;
							ans.position = IDX_W'(cur);
						end
					end
				end
			end
		endcase
		return ans;
	endfunction

	task automatic push_op(kind_t k, int idx, bit setv, bit chk, bit cons, int start, bit up);
		bitmap_op_t op;
		op.kind           = k;
		op.bit_addr       = IDX_W'(idx);
		op.set_value      = setv;
		op.range_check    = chk;
		op.consume        = cons;
		op.start_position = START_W'(start);
		op.search_up      = up;
		pending_ops.push_back(op);
	endtask

	// Random content, with indexes and starts biased toward the size boundary
	task automatic queue_random_ops(int count);
		bitmap_op_t  op;
		int unsigned size;
		int unsigned span;
		int unsigned pick;
		int          idx;
		int          start;
		size = active_size();
		span = (size == 0) ? 1 : size;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op.kind = KIND_WRITE;
			else if (pick < 60)
				op.kind = KIND_READ;
			else if (pick < 80)
				op.kind = KIND_FIRST;
			else
				op.kind = KIND_NEXT;
			pick = $urandom_range(99);
			if (pick < 60)
				idx = $urandom_range(span - 1);
			else if (pick < 80)
				idx = int'(size) - 1 + int'($urandom_range(8));
			else
				idx = $urandom_range(ARRAY_BITS - 1);
			if (idx < 0)
				idx = 0;
			if (idx > ARRAY_BITS - 1)
				idx = ARRAY_BITS - 1;
			pick = $urandom_range(99);
			if (pick < 10)
				start = -1;
			else if (pick < 20)
				start = ARRAY_BITS;
			else
				start = int'($urandom_range(span + 1)) - 1;
			op.bit_addr       = IDX_W'(idx);
			op.set_value      = ($urandom_range(99) < 40);
			op.range_check    = 1'($urandom_range(1));
			op.consume        = 1'($urandom_range(1));
			op.start_position = START_W'(start);
			op.search_up      = 1'($urandom_range(1));
			pending_ops.push_back(op);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_ops.size() != 0 || in_valid || expected_answers.size() != 0)
			@(negedge clk);
	endtask

	// Reprogram the size once nothing is in flight, and set the idle rates
	task automatic apply_size(int unsigned value, int gap_pct, int idle_pct);
		wait_drained();
		@(posedge clk);
		cfg_write    <= 1'b1;
		bits_in_use  <= CFG_W'(value);
		send_gap_pct <= gap_pct;
		stall_pct    <= idle_pct;
		size_setting = value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic flag_error(string what, bitmap_answer_t want, bitmap_answer_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s: expected found=%0b position=%0d bit_value=%0b, got found=%0b position=%0d bit_value=%0b",
				$realtime, what, want.found, want.position, want.bit_value,
				got.found, got.position, got.bit_value);
	endtask

	// Driver: take the next pending operation once the current transaction goes through
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_answers.push_back(predict_bitmap_op(offered));
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					offered = pending_ops.pop_front();
					in_valid       <= 1'b1;
					kind           <= offered.kind;
					bit_addr       <= offered.bit_addr;
					set_value      <= offered.set_value;
					range_check    <= offered.range_check;
					consume        <= offered.consume;
					start_position <= offered.start_position;
					search_up      <= offered.search_up;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expected answer
	always @(posedge clk) begin
		bitmap_answer_t got;
		bitmap_answer_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.found     = found;
				got.position  = position;
				got.bit_value = bit_value;
				if (expected_answers.size() == 0) begin
					flag_error("unexpected result", '0, got);
				end else begin
					want = expected_answers.pop_front();
					if (got !== want)
						flag_error("result mismatch", want, got);
				end
			end
			out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
		end
	end

	// Long receiver hold-off, so that the engine backs up and stalls its input
	always @(posedge clk) begin
		if (hold_trigger && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		apply_size(ARRAY_BITS, 20, 54);
		// ends of the array, wrap in both directions, starts outside the range
		push_op(KIND_READ,  0,   0, 0, 0, 0,          0);
		push_op(KIND_WRITE, 0,   1, 1, 0, 0,          0);
		push_op(KIND_WRITE, 255, 1, 1, 0, 0,          0);
		push_op(KIND_READ,  0,   0, 0, 0, 0,          0);
		push_op(KIND_READ,  255, 0, 0, 0, 0,          0);
		push_op(KIND_FIRST, 0,   0, 0, 0, 0,          0);
		push_op(KIND_NEXT,  0,   0, 0, 0, 0,          1);
		push_op(KIND_NEXT,  0,   0, 0, 0, 0,          0);
		push_op(KIND_NEXT,  0,   0, 0, 0, -1,         1);
		push_op(KIND_NEXT,  0,   0, 0, 0, ARRAY_BITS, 0);
		push_op(KIND_NEXT,  0,   0, 0, 0, 255,        1);
		push_op(KIND_FIRST, 0,   0, 0, 1, 0,          0);
		push_op(KIND_FIRST, 0,   0, 0, 1, 0,          0);
		push_op(KIND_FIRST, 0,   0, 0, 0, 0,          0);
		push_op(KIND_NEXT,  0,   0, 0, 0, 100,        0);
		queue_random_ops(280);

		// size not a whole number of bytes: checked writes and find-first past the size
		apply_size(13, 20, 54);
		push_op(KIND_WRITE, 14, 1, 1, 0, 0,          0);
		push_op(KIND_READ,  14, 0, 0, 0, 0,          0);
		push_op(KIND_WRITE, 14, 1, 0, 0, 0,          0);
		push_op(KIND_FIRST, 0,  0, 0, 1, 0,          0);
		push_op(KIND_READ,  14, 0, 0, 0, 0,          0);
		push_op(KIND_WRITE, 12, 1, 1, 0, 0,          0);
		push_op(KIND_NEXT,  0,  0, 0, 0, ARRAY_BITS, 1);
		push_op(KIND_WRITE, 12, 0, 0, 0, 0,          0);
		queue_random_ops(280);

		apply_size(1, 54, 20);
		queue_random_ops(100);
		apply_size(0, 54, 20);
		queue_random_ops(60);
		apply_size(511, 54, 20);
		queue_random_ops(250);

		apply_size(8, 0, 0);
		hold_trigger <= 1'b1;
		queue_random_ops(300);
		apply_size(255, 0, 0);
		queue_random_ops(350);
		apply_size(ARRAY_BITS, 0, 0);
		queue_random_ops(300);

		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pbse_pkg.sv
rtl/core/pbse_scan.sv
rtl/core/packed_bitmap_search_engine.sv
tb/packed_bitmap_search_engine_test.sv
